@@ hw/rtl/text_line_number_caret_filter_unit_defines.svh @@
// Assertion macros shared by the text line number and caret filter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TEXT_LINE_NUMBER_CARET_FILTER_UNIT_DEFINES_SVH
`define TEXT_LINE_NUMBER_CARET_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TLNCF_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TLNCF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tlncf_pkg.sv @@
// Package for the text line number and caret filter: character codes,
// register indexes and the job record passed from front to back. No dependencies.
package tlncf_pkg;

   // Character codes
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CTRL_LIMIT = 8'd32;

   // Entries in the job queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_NUMBER_ALL      = 2'd0,
      CSR_NUMBER_NONBLANK = 2'd1,
      CSR_SHOW_CONTROL    = 2'd2,
      CSR_TAB_CARET       = 2'd3
   } tlncf_csr_type;

   // One classified input byte
   typedef struct packed {
      logic       number;   // emit the line number prefix first
      logic       caret;    // emit '^' before data
      logic [7:0] data;     // final byte of the beat run
   } tlncf_job_type;

endpackage

@@ hw/rtl/tlncf_front.sv @@
// Front end of the filter: configuration registers, line state, BCD line count
// and classification of each input byte into a job. Depends on tlncf_pkg.
`include "text_line_number_caret_filter_unit_defines.svh"

module tlncf_front import tlncf_pkg::*; #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [0:0]                    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_in_byte,
   input  logic                          queue_full,
   output logic                          push,
   output tlncf_job_type                 push_job,
   output logic [NUMBER_DIGITS-1:0][3:0] push_digits,
   output logic [NUMBER_DIGITS-1:0]      push_blank
);

   localparam logic [NUMBER_DIGITS*4-1:0] COUNT_ONE = (NUMBER_DIGITS*4)'(1);

   logic                          number_all_ff;
   logic                          number_nonblank_ff;
   logic                          show_control_ff;
   logic                          tab_caret_ff;
   logic [NUMBER_DIGITS-1:0][3:0] count_ff, count_in;
   logic                          at_start_ff, at_start_in;
   logic                          accept;
   logic                          is_lf;
   logic                          do_number;
   logic                          carry;
   logic                          zero_run;

   // Accept whenever the queue has room
   assign req_stall = queue_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = accept;

   // Classify the byte
   assign is_lf     = (req_in_byte == CHAR_LF);
   assign do_number = at_start_ff &
                      (number_all_ff | (number_nonblank_ff & ~is_lf));

   always_comb begin
      push_job.number = do_number;
      push_job.caret  = 1'b0;
      push_job.data   = req_in_byte;
      priority if (show_control_ff && (req_in_byte < CTRL_LIMIT) && !is_lf &&
                   (req_in_byte != CHAR_TAB)) begin
         push_job.caret = 1'b1;
         push_job.data  = CHAR_AT | req_in_byte;
      end else if (tab_caret_ff && (req_in_byte == CHAR_TAB)) begin
         push_job.caret = 1'b1;
         push_job.data  = CHAR_I;
      end else begin
         push_job.data  = req_in_byte;
      end
   end

   // Hand the current count to the back end, with its leading-space mask
   assign push_digits = count_ff;

   always_comb begin
      zero_run = 1'b1;
      for (int j = NUMBER_DIGITS - 1; j >= 0; j--) begin
         zero_run      = zero_run & (count_ff[j] == 4'd0);
         push_blank[j] = zero_run & (j != 0);
      end
   end

   // Advance the BCD count, hold at all nines
   always_comb begin
      carry = 1'b1;
      for (int j = 0; j < NUMBER_DIGITS; j++) begin
         if (carry) begin
            count_in[j] = (count_ff[j] == 4'd9) ? 4'd0 : count_ff[j] + 4'd1;
         end else begin
            count_in[j] = count_ff[j];
         end
         carry = carry & (count_ff[j] == 4'd9);
      end
      if (carry) begin
         count_in = count_ff;
      end
   end

   // Line start: cleared by a number, set by a newline
   always_comb begin
      at_start_in = at_start_ff;
      if (do_number) begin
         at_start_in = 1'b0;
      end
      if (is_lf) begin
         at_start_in = 1'b1;
      end
   end

   // Hold configuration and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         number_all_ff      <= 1'b0;
         number_nonblank_ff <= 1'b0;
         show_control_ff    <= 1'b0;
         tab_caret_ff       <= 1'b0;
         count_ff           <= COUNT_ONE;
         at_start_ff        <= 1'b1;
      end else begin
         if (csr_write_en) begin
            unique case (tlncf_csr_type'(csr_index))
               CSR_NUMBER_ALL:      number_all_ff      <= csr_wdata[0];
               CSR_NUMBER_NONBLANK: number_nonblank_ff <= csr_wdata[0];
               CSR_SHOW_CONTROL:    show_control_ff    <= csr_wdata[0];
               CSR_TAB_CARET:       tab_caret_ff       <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            at_start_ff <= at_start_in;
            if (do_number) begin
               count_ff <= count_in;
            end
         end
      end
   end

   `TLNCF_ASSERT_NOW(a_no_push_full, clock, reset, queue_full, !push, "push into full queue")
   `TLNCF_ASSERT_NEXT(a_number_clears_start, clock, reset, accept && do_number && !is_lf, !at_start_ff, "line start not cleared after number")

endmodule

@@ hw/rtl/tlncf_queue.sv @@
// Short job queue in flip-flops between the front and back ends of the filter.
// Depends on tlncf_pkg for its depth.
`include "text_line_number_caret_filter_unit_defines.svh"

module tlncf_queue import tlncf_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNTW-1:0] COUNT_FULL = CNTW'(QUEUE_DEPTH);
   localparam logic [PTRW-1:0] PTR_LAST   = PTRW'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full       = (count_ff == COUNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TLNCF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_FULL, "queue count over depth")
   `TLNCF_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, count_ff != '0, "pop from empty queue")

endmodule

@@ hw/rtl/tlncf_back.sv @@
// Back end of the filter: expands the job at the queue head into output beats
// through a registered output stage. Depends on tlncf_pkg.
`include "text_line_number_caret_filter_unit_defines.svh"

module tlncf_back import tlncf_pkg::*; #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  tlncf_job_type                 head_job,
   input  logic [NUMBER_DIGITS-1:0][3:0] head_digits,
   input  logic [NUMBER_DIGITS-1:0]      head_blank,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run
);

   localparam int PW = $clog2(NUMBER_DIGITS + 3);
   localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
   localparam logic [PW-1:0] POS_TOP  = PW'(NUMBER_DIGITS - 1);
   localparam logic [PW-1:0] POS_TAB  = PW'(NUMBER_DIGITS);
   localparam logic [PW-1:0] POS_CHAR = PW'(NUMBER_DIGITS + 1);
   localparam logic [PW-1:0] POS_DATA = PW'(NUMBER_DIGITS + 2);

   logic [PW-1:0] pos_ff, pos_in;
   logic          valid_ff;
   logic [7:0]    byte_ff;
   logic          last_ff;
   logic [PW-1:0] eff;
   logic [PW-1:0] sel;
   logic [DW-1:0] digit_idx;
   logic [3:0]    digit;
   logic [7:0]    gen_byte;
   logic          gen_last;
   logic          advance;

   // Position within the full run; jobs without a number skip the prefix
   assign eff       = head_job.number ? pos_ff : pos_ff + POS_CHAR;
   assign sel       = POS_TOP - eff;
   assign digit_idx = sel[DW-1:0];
   assign digit     = head_digits[digit_idx];

   // Pick the beat for this position
   always_comb begin
      priority if (eff < POS_TAB) begin
         gen_byte = head_blank[digit_idx] ? CHAR_SPACE : (CHAR_ZERO | {4'd0, digit});
      end else if (eff == POS_TAB) begin
         gen_byte = CHAR_TAB;
      end else if (eff == POS_CHAR) begin
         gen_byte = head_job.caret ? CHAR_CARET : head_job.data;
      end else begin
         gen_byte = head_job.data;
      end
   end

   assign gen_last = ((eff == POS_CHAR) && !head_job.caret) || (eff == POS_DATA);

   // Load the output register when it is empty or being taken
   assign advance = head_valid & (~valid_ff | ~rsp_stall);
   assign pop     = advance & gen_last;

   always_comb begin
      pos_in = pos_ff;
      if (advance) begin
         pos_in = gen_last ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         pos_ff <= pos_in;
         if (!valid_ff || !rsp_stall) begin
            valid_ff <= head_valid;
         end
      end
   end

   // Output payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= gen_byte;
         last_ff <= gen_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

   `TLNCF_ASSERT_NOW(a_pos_bound, clock, reset, 1'b1, pos_ff <= POS_DATA, "run position out of range")
   `TLNCF_ASSERT_NEXT(a_pos_step, clock, reset, advance && !gen_last, pos_ff == $past(pos_ff) + 1'b1, "run position did not step")

endmodule

@@ hw/rtl/text_line_number_caret_filter_unit.sv @@
// Text line number and caret filter. Each input beat is one byte of text;
// it yields a run of 1 to NUMBER_DIGITS+3 output beats, last_of_run marking
// the final one. A line number (right-justified, space padded, then a tab)
// leads the first byte of a line when numbering is on; control bytes and tab
// may come out as caret pairs. The output stage sends one beat per cycle
// while jobs are queued and rsp_stall is low. Input is taken while the
// four-entry job queue has room, independent of the output stall. Configuration
// is written through csr_*, which the user must do only while the block is idle;
// the block itself does not enforce it. Only bit 0 of the data is used.
// Depends on tlncf_pkg, tlncf_front, tlncf_queue and tlncf_back.
module text_line_number_caret_filter_unit import tlncf_pkg::*; #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [0:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   localparam int JOBW   = $bits(tlncf_job_type);
   localparam int QWIDTH = JOBW + NUMBER_DIGITS * 5;

   logic                          push;
   tlncf_job_type                 push_job;
   logic [NUMBER_DIGITS-1:0][3:0] push_digits;
   logic [NUMBER_DIGITS-1:0]      push_blank;
   logic                          queue_full;
   logic                          pop;
   logic                          head_valid;
   logic [QWIDTH-1:0]             head_data;
   tlncf_job_type                 head_job;
   logic [NUMBER_DIGITS-1:0][3:0] head_digits;
   logic [NUMBER_DIGITS-1:0]      head_blank;

   // Classify bytes and keep line state
   tlncf_front #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .queue_full   (queue_full),
      .push         (push),
      .push_job     (push_job),
      .push_digits  (push_digits),
      .push_blank   (push_blank)
   );

   // Decouple front and back
   tlncf_queue #(
      .WIDTH (QWIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_job, push_digits, push_blank}),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_job    = tlncf_job_type'(head_data[QWIDTH-1 -: JOBW]);
   assign head_digits = head_data[NUMBER_DIGITS*5-1 : NUMBER_DIGITS];
   assign head_blank  = head_data[NUMBER_DIGITS-1:0];

   // Expand jobs into output beats
   tlncf_back #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .head_digits     (head_digits),
      .head_blank      (head_blank),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ verif/tb_text_line_number_caret_filter_unit.sv @@
// Self-checking bench for text_line_number_caret_filter_unit: line numbering, caret
// notation and tab display, predicted beat by beat in a small scoreboard class.
// Depends on tlncf_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb_text_line_number_caret_filter_unit;
   import tlncf_pkg::*;

   localparam int    DIGITS      = 6;
   localparam int    CYCLE_LIMIT = 400000;
   localparam int    DRAIN_WAIT  = 20;
   localparam int    RANDOM_ITEMS = 446;

   logic       clock;
   logic       reset;
   logic       csr_write_en;
   logic [1:0] csr_index;
   logic [0:0] csr_wdata;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   // Gaps on both channels are drawn only while this is set
   logic       idle_on;
   int         cycle_count;

   text_line_number_caret_filter_unit #(
      .NUMBER_DIGITS (DIGITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Predicts the formatted beats of each input byte and checks them in order
   class caret_filter_scoreboard;
      typedef struct packed {
         logic [7:0] data;
         logic       is_last;
      } out_beat_type;

      logic         number_all;
      logic         number_nonblank;
      logic         show_control;
      logic         tab_caret;
      longint       next_number;
      logic         line_start;
      out_beat_type expected_beats[$];
      int           mismatches;

      function new();
         number_all      = 1'b0;
         number_nonblank = 1'b0;
         show_control    = 1'b0;
         tab_caret       = 1'b0;
         next_number     = 1;
         line_start      = 1'b1;
         mismatches      = 0;
      endfunction

      function void set_register(tlncf_csr_type idx, logic value);
         case (idx)
            CSR_NUMBER_ALL:      number_all      = value;
            CSR_NUMBER_NONBLANK: number_nonblank = value;
            CSR_SHOW_CONTROL:    show_control    = value;
            CSR_TAB_CARET:       tab_caret       = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // Work out the run of beats for one accepted byte
      function void note_input_byte(logic [7:0] c);
         logic [7:0]   run_bytes[$];
         int           digit_val[DIGITS];
         longint       v;
         longint       count_max;
         logic         leading;
         out_beat_type beat;
         count_max = 1;
         for (int i = 0; i < DIGITS; i++) count_max = count_max * 10;
         count_max = count_max - 1;
         // Line number prefix: space padded, right-justified, then a tab
         if (line_start && (number_all || (number_nonblank && c != CHAR_LF))) begin
            v = next_number;
            for (int i = DIGITS - 1; i >= 0; i--) begin
               digit_val[i] = int'(v % 10);
               v = v / 10;
            end
            leading = 1'b1;
            for (int i = 0; i < DIGITS; i++) begin
               if (digit_val[i] != 0 || i == DIGITS - 1) leading = 1'b0;
               run_bytes.push_back(leading ? CHAR_SPACE : CHAR_ZERO + 8'(digit_val[i]));
            end
            run_bytes.push_back(CHAR_TAB);
            if (next_number < count_max) next_number = next_number + 1;
            line_start = 1'b0;
         end
         // Byte itself, possibly in caret form
         if (show_control && c < CTRL_LIMIT && c != CHAR_LF && c != CHAR_TAB) begin
            run_bytes.push_back(CHAR_CARET);
            run_bytes.push_back(CHAR_AT + c);
         end else if (tab_caret && c == CHAR_TAB) begin
            run_bytes.push_back(CHAR_CARET);
            run_bytes.push_back(CHAR_I);
         end else begin
            run_bytes.push_back(c);
         end
         if (c == CHAR_LF) line_start = 1'b1;
         foreach (run_bytes[i]) begin
            beat.data    = run_bytes[i];
            beat.is_last = (i == run_bytes.size() - 1);
            expected_beats.push_back(beat);
         end
      endfunction

      // Compare one accepted output beat with the oldest expectation
      function void check_output_beat(logic [7:0] data, logic is_last);
         out_beat_type exp_beat;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected beat data=%02h last=%0b", $time, data, is_last);
            return;
         end
         exp_beat = expected_beats.pop_front();
         if (data !== exp_beat.data || is_last !== exp_beat.is_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: beat mismatch exp data=%02h last=%0b, got data=%02h last=%0b",
                        $time, exp_beat.data, exp_beat.is_last, data, is_last);
         end
      endfunction
   endclass

   caret_filter_scoreboard sb;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Send one byte; called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input_byte(b);
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] text[$]);
      foreach (text[i]) send_byte(text[i]);
   endtask

   // Hold off input until every expected beat is out, then write all four registers
   task automatic settle_and_configure(input logic [3:0] bits);
      tlncf_csr_type idx;
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         idx = tlncf_csr_type'(i);
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_wdata    <= bits[i];
         sb.set_register(idx, bits[i]);
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // Pick a text-like byte: newlines, tabs and control bytes show up often
   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0, 1:    return CHAR_LF;
         2:       return CHAR_TAB;
         3, 4:    return 8'($urandom_range(0, 31));
         5:       return 8'($urandom_range(0, 255));
         6:       return 8'($urandom_range(127, 255));
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   // Result side: random stall ahead of each beat
   initial begin
      int stall_cycles;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall_cycles = idle_on ? $urandom_range(0, 9) : 0;
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         sb.check_output_beat(rsp_out_byte, rsp_last_of_run);
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin
      logic [7:0] text[$];
      logic [3:0] bits;
      int         sent;
      int         phase_len;
      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = CSR_NUMBER_ALL;
      csr_wdata    = 1'b0;
      req_valid    = 1'b0;
      req_in_byte  = 8'h00;
      rsp_stall    = 1'b0;
      idle_on      = 1'b1;
      cycle_count  = 0;
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: everything passes through, line start never clears
      text = {8'h41, 8'h00, CHAR_TAB, CHAR_LF, 8'hFF, 8'h7F, 8'h1F};
      send_text(text);
      // Number all with carets: mid-line byte gets a number, carets for control and tab
      settle_and_configure(4'b1101);
      text = {8'h00, 8'h1B, CHAR_TAB, CHAR_LF, CHAR_LF, 8'h20, 8'h80, CHAR_LF};
      send_text(text);
      // Nonblank numbering only: blank lines stay unnumbered
      settle_and_configure(4'b0010);
      text = {CHAR_LF, CHAR_LF, 8'h61, CHAR_TAB, 8'h01, CHAR_LF};
      send_text(text);
      // Number-all overrides nonblank, every register set
      settle_and_configure(4'b1111);
      text = {CHAR_LF, 8'h62, CHAR_LF};
      send_text(text);

      // Random phases with random settings, some without any idling
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       bits = 4'b0000;
            1:       bits = 4'b1111;
            default: bits = 4'($urandom_range(0, 15));
         endcase
         settle_and_configure(bits);
         idle_on   = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(10, 60);
         if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
         for (int i = 0; i < phase_len; i++) send_byte(pick_text_byte());
         sent = sent + phase_len;
      end

      // Drain and finish
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
